// ----- hdl/hsrt_pkg.sv -----
package hsrt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [31:0] HASH_MUL   = 32'd2654435761;
    localparam logic [27:0] RATE_MAX   = 28'hFFFFFFF;
    localparam logic [27:0] RATE_NUM   = 28'd256000000;
    localparam logic [9:0]  MS_TO_US   = 10'd1000;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [5:0]  INST_STEPS = 6'd28;
    localparam logic [5:0]  ALPHA_STEPS = 6'd16;

    localparam logic [7:0] CFG_TAU = 8'd0;
    localparam logic [7:0] CFG_EN  = 8'd1;

    typedef enum logic [1:0] {
        MODE_REG   = 2'd0,
        MODE_UNREG = 2'd1,
        MODE_SPIKE = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      key;
        logic [47:0]      time_us;
        logic [IDX_W-1:0] home;
    } item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [47:0] last_us;
        logic [27:0] avg;
        logic [31:0] tally;
    } row_t;

    typedef struct packed {
        logic [15:0] tau_ms;
        logic        enable;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [47:0] rem_init;
        logic [27:0] num;
        logic [47:0] den;
        logic [5:0]  steps;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CK,
        ST_DT,
        ST_INST_GO,
        ST_INST_WAIT,
        ST_ALPHA_GO,
        ST_ALPHA_WAIT,
        ST_MUL,
        ST_BLEND,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/hsrt_fifo.sv -----
module hsrt_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hsrt_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output hsrt_pkg::item_t head_item
);
    import hsrt_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head_item = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !full) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && not_empty) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push && !full, pop && not_empty})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/hsrt_front.sv -----
module hsrt_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [79:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            clearing,
    input  logic            fifo_full,
    output logic            push,
    output hsrt_pkg::item_t push_item
);
    import hsrt_pkg::*;

    logic        stg_valid_reg, stg_valid_next;
    logic [1:0]  stg_mode_reg;
    logic [31:0] stg_key_reg;
    logic [47:0] stg_time_reg;
    logic [31:0] hash;
    logic        accept;

    assign s_tready = !clearing && (!stg_valid_reg || !fifo_full);
    assign accept   = s_tvalid && s_tready;
    assign push     = stg_valid_reg && !fifo_full;

    // multiplicative hash, wrapping 32 bits
    assign hash = stg_key_reg * HASH_MUL;

    always_comb begin
        push_item.mode    = stg_mode_reg;
        push_item.key     = stg_key_reg;
        push_item.time_us = stg_time_reg;
        push_item.home    = hash[IDX_W-1:0];
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (push) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_mode_reg <= s_tuser;
            stg_key_reg  <= s_tdata[31:0];
            stg_time_reg <= s_tdata[79:32];
        end
    end

endmodule

// ----- hdl/hsrt_div.sv -----
module hsrt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  hsrt_pkg::div_req_t req,
    output logic               busy,
    output logic [27:0]        quo
);
    import hsrt_pkg::*;

    logic        busy_reg, busy_next;
    logic [47:0] rem_reg, rem_next;
    logic [27:0] num_reg, num_next;
    logic [27:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [48:0] trial;

    assign busy  = busy_reg;
    assign quo   = quo_reg;
    assign trial = {rem_reg, num_reg[27]};

    // restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = req.rem_init;
            num_next  = req.num;
            quo_next  = '0;
            cnt_next  = req.steps;
        end else if (busy_reg) begin
            num_next = {num_reg[26:0], 1'b0};
            if (trial >= {1'b0, req.den}) begin
                rem_next = 48'(trial - {1'b0, req.den});
                quo_next = {quo_reg[26:0], 1'b1};
            end else begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[26:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- hdl/hsrt_back.sv -----
module hsrt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  hsrt_pkg::cfg_t     cfg,
    input  logic               fifo_not_empty,
    input  hsrt_pkg::item_t    head_item,
    output logic               pop,
    output logic               clearing,
    output hsrt_pkg::div_req_t div_req,
    input  logic               div_busy,
    input  logic [27:0]        div_quo,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import hsrt_pkg::*;

    mark_t mark_mem [TABLE_DEPTH];
    row_t  row_mem  [TABLE_DEPTH];
    mark_t mark_q;
    row_t  row_q;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] clr_reg, clr_next;
    item_t            item_reg, item_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             free_vld_reg, free_vld_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [47:0]      dt_reg, dt_next;
    logic [25:0]      span_reg, span_next;
    logic [27:0]      inst_reg, inst_next;
    logic [16:0]      alpha_reg, alpha_next;
    logic [44:0]      p1_reg, p1_next;
    logic [44:0]      p2_reg, p2_next;
    status_t          st_reg, st_next;
    logic [27:0]      rate_res_reg, rate_res_next;
    logic [31:0]      tot_res_reg, tot_res_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg;
    logic [27:0]      m_rate_reg;
    logic [31:0]      m_total_reg;

    logic             mark_we;
    logic [IDX_W-1:0] mark_wa;
    mark_t            mark_wd;
    logic             row_we;
    logic [IDX_W-1:0] row_wa;
    row_t             row_wd;

    logic             hit, last_slot, new_free_vld, out_load;
    logic [IDX_W-1:0] new_free_idx;
    logic [45:0]      acc;
    logic [29:0]      acc_sh;
    logic [27:0]      new_avg;
    logic [31:0]      new_tally;

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_total_reg, m_rate_reg};
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign hit       = (mark_q == MARK_LIVE) && (row_q.key == item_reg.key);
    assign last_slot = (n_reg == CNT_W'(TABLE_DEPTH - 1));
    assign new_free_vld = free_vld_reg || (mark_q == MARK_DELETED);
    assign new_free_idx = free_vld_reg ? free_idx_reg : idx_reg;

    assign acc       = {1'b0, p1_reg} + {1'b0, p2_reg} + 46'd32768;
    assign acc_sh    = acc[45:16];
    assign new_avg   = (acc_sh > {2'b0, RATE_MAX}) ? RATE_MAX : acc_sh[27:0];
    assign new_tally = (row_q.tally == 32'hFFFFFFFF) ? row_q.tally : row_q.tally + 32'd1;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        dt_next       = dt_reg;
        span_next     = span_reg;
        inst_next     = inst_reg;
        alpha_next    = alpha_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        st_next       = st_reg;
        rate_res_next = rate_res_reg;
        tot_res_next  = tot_res_reg;
        m_valid_next  = m_valid_reg;
        pop           = 1'b0;
        mark_we       = 1'b0;
        mark_wa       = idx_reg;
        mark_wd       = MARK_LIVE;
        row_we        = 1'b0;
        row_wa        = idx_reg;
        row_wd        = '{key: item_reg.key, last_us: 48'd0, avg: 28'd0, tally: 32'd0};
        div_req       = '{start: 1'b0, rem_init: 48'd0, num: RATE_NUM,
                          den: dt_reg, steps: INST_STEPS};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // mark memory sweep, one slot a cycle
                mark_we  = 1'b1;
                mark_wa  = clr_reg[IDX_W-1:0];
                mark_wd  = MARK_EMPTY;
                clr_next = clr_reg + CNT_W'(1);
                if (clr_reg == CNT_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (fifo_not_empty) begin
                    pop           = 1'b1;
                    item_next     = head_item;
                    idx_next      = head_item.home;
                    n_next        = '0;
                    free_vld_next = 1'b0;
                    st_next       = STAT_OK;
                    rate_res_next = '0;
                    tot_res_next  = '0;
                    state_next    = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                state_next = ST_PROBE_CK;
            end
            ST_PROBE_CK: begin
                if (item_reg.mode == MODE_REG) begin
                    if (hit) begin
                        row_we     = 1'b1;
                        state_next = ST_DONE;
                    end else if (mark_q == MARK_EMPTY || last_slot) begin
                        if (mark_q == MARK_EMPTY || new_free_vld) begin
                            mark_we = 1'b1;
                            row_we  = 1'b1;
                            mark_wa = (mark_q == MARK_EMPTY) ? new_free_idx :
                                      (free_vld_reg ? free_idx_reg : idx_reg);
                            row_wa  = mark_wa;
                        end else begin
                            st_next = STAT_FULL;
                        end
                        state_next = ST_DONE;
                    end else begin
                        free_vld_next = new_free_vld;
                        if (!free_vld_reg) begin
                            free_idx_next = idx_reg;
                        end
                        idx_next   = idx_reg + IDX_W'(1);
                        n_next     = n_reg + CNT_W'(1);
                        state_next = ST_PROBE_RD;
                    end
                end else begin
                    if (hit) begin
                        if (item_reg.mode == MODE_UNREG) begin
                            mark_we    = 1'b1;
                            mark_wd    = MARK_DELETED;
                            state_next = ST_DONE;
                        end else if (item_reg.mode == MODE_SPIKE && cfg.enable) begin
                            state_next = ST_DT;
                        end else begin
                            rate_res_next = row_q.avg;
                            tot_res_next  = row_q.tally;
                            state_next    = ST_DONE;
                        end
                    end else if (mark_q == MARK_EMPTY || last_slot) begin
                        st_next    = STAT_NOTFOUND;
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        n_next     = n_reg + CNT_W'(1);
                        state_next = ST_PROBE_RD;
                    end
                end
            end
            ST_DT: begin
                dt_next    = item_reg.time_us - row_q.last_us;
                span_next  = 26'(cfg.tau_ms) * 26'(MS_TO_US);
                state_next = ST_INST_GO;
            end
            ST_INST_GO: begin
                if (dt_reg == 48'd0) begin
                    inst_next  = '0;
                    state_next = ST_ALPHA_GO;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_INST_WAIT;
                end
            end
            ST_INST_WAIT: begin
                if (!div_busy) begin
                    inst_next  = div_quo;
                    state_next = ST_ALPHA_GO;
                end
            end
            ST_ALPHA_GO: begin
                div_req.den = {22'd0, span_reg};
                if (span_reg == 26'd0 || dt_reg >= {22'd0, span_reg}) begin
                    alpha_next = ALPHA_ONE;
                    state_next = ST_MUL;
                end else begin
                    // dt below span: quotient of dt*2^16/span fits 16 bits
                    div_req.start    = 1'b1;
                    div_req.rem_init = dt_reg;
                    div_req.num      = '0;
                    div_req.steps    = ALPHA_STEPS;
                    state_next       = ST_ALPHA_WAIT;
                end
            end
            ST_ALPHA_WAIT: begin
                div_req.den = {22'd0, span_reg};
                if (!div_busy) begin
                    alpha_next = {1'b0, div_quo[15:0]};
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                p1_next    = (ALPHA_ONE - alpha_reg) * row_q.avg;
                p2_next    = alpha_reg * inst_reg;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                row_we        = 1'b1;
                row_wd        = '{key: item_reg.key, last_us: item_reg.time_us,
                                  avg: new_avg, tally: new_tally};
                rate_res_next = new_avg;
                tot_res_next  = new_tally;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        dt_reg       <= dt_next;
        span_reg     <= span_next;
        inst_reg     <= inst_next;
        alpha_reg    <= alpha_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        st_reg       <= st_next;
        rate_res_reg <= rate_res_next;
        tot_res_reg  <= tot_res_next;
        if (out_load) begin
            m_status_reg <= st_reg;
            m_rate_reg   <= rate_res_reg;
            m_total_reg  <= tot_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_q <= mark_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        row_q <= row_mem[idx_reg];
    end

endmodule

// ----- hdl/hashed_spike_rate_tracker.sv -----
// path: an accepted item is registered in the front stage, queued, and probed by the
// back end slot by slot (a read and a check state each); the result is registered
// a spike updating an entry runs up to 28 + 16 divider steps, a multiply and a blend
// the back end takes one item at a time; the front stage and a 2-item queue take more
// reset: synchronous, active low; a pass then clears all 1024 slot marks,
// during which no item is accepted (configuration writes are taken)
module hashed_spike_rate_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // neuron_key[31:0], time_us[79:32]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rate_hz[27:0], spike_total[59:28], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hsrt_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     clearing, fifo_full, fifo_not_empty, push, pop, div_busy;
    item_t    push_item, head_item;
    div_req_t div_req;
    logic [27:0] div_quo;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TAU: cfg_next.tau_ms = cfg_data;
                CFG_EN:  cfg_next.enable = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{tau_ms: 16'd100, enable: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hsrt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    hsrt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head_item (head_item)
    );

    hsrt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    hsrt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .fifo_not_empty (fifo_not_empty),
        .head_item      (head_item),
        .pop            (pop),
        .clearing       (clearing),
        .div_req        (div_req),
        .div_busy       (div_busy),
        .div_quo        (div_quo),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_fail_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != 2'(STAT_OK)) |-> (m_tdata == 64'd0))
        else $error("nonzero result fields on failed item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> fifo_not_empty)
        else $error("queue popped while empty");

endmodule
